// ===== sv/mbtd_pkg.sv =====
// shared types and constants for the modulated beam trip detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbtd_pkg;

	localparam int unsigned SAMPLE_W  = 10;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned THRESH_W  = 10;
	localparam int unsigned HOLD_W    = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS     = CFG_IDX_W'(1);

	localparam logic [THRESH_W-1:0] CHANGE_THRESHOLD_RST = THRESH_W'(20);
	localparam logic [HOLD_W-1:0]   HOLD_TIME_MS_RST     = HOLD_W'(500);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_STOP   = 1'b1;

	localparam logic [1:0] MISS_MAX    = 2'd3;
	localparam logic [1:0] MISS_TRIP   = 2'd1;
	localparam logic [2:0] COUNT_MAX   = 3'd7;
	localparam logic [2:0] RECOVER_LIM = 3'd3;
	localparam logic [2:0] HIT_RUN_LIM = 3'd5;

	typedef struct packed {
		logic                cmd;
		logic [SAMPLE_W-1:0] sample_value;
		logic [TIME_W-1:0]   now_ms;
	} in_t;

	typedef struct packed {
		logic laser_drive;
		logic indicator_led;
		logic tripped;
		logic trip_finished;
	} out_t;

	typedef struct packed {
		logic [THRESH_W-1:0] change_threshold;
		logic [HOLD_W-1:0]   hold_time_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/mbtd_core.sv =====
// detector state and per-sample update logic
// depends on mbtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbtd_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire mbtd_pkg::in_t  item,
	input  wire mbtd_pkg::cfg_t cfg,
	output mbtd_pkg::out_t    res
);
	import mbtd_pkg::*;

	logic                drive_q;
	logic [SAMPLE_W-1:0] last_q;
	logic [1:0]          miss_q;
	logic [2:0]          recover_q;
	logic [2:0]          hit_run_q;
	logic                trip_q;
	logic                ended_q;
	logic                led_q;
	logic [TIME_W-1:0]   hold_start_q;

	logic                drive_d;
	logic [SAMPLE_W-1:0] last_d;
	logic [1:0]          miss_d;
	logic [2:0]          recover_d;
	logic [2:0]          hit_run_d;
	logic                trip_d;
	logic                ended_d;
	logic                led_d;
	logic [TIME_W-1:0]   hold_start_d;

	logic [SAMPLE_W:0]   up_sum;
	logic [SAMPLE_W:0]   down_sum;
	logic                hit;
	logic [2:0]          rc_inc;
	logic [TIME_W-1:0]   elapsed;

	assign up_sum   = {1'b0, last_q} + {1'b0, cfg.change_threshold};
	assign down_sum = {1'b0, item.sample_value} + {1'b0, cfg.change_threshold};
	assign elapsed  = item.now_ms - hold_start_q;

	always_comb begin
		drive_d      = drive_q;
		last_d       = last_q;
		miss_d       = miss_q;
		recover_d    = recover_q;
		hit_run_d    = hit_run_q;
		trip_d       = trip_q;
		ended_d      = ended_q;
		led_d        = led_q;
		hold_start_d = hold_start_q;
		hit          = 1'b0;
		rc_inc       = recover_q;
		if (item.cmd == CMD_STOP) begin
			drive_d   = 1'b1;
			led_d     = 1'b0;
			trip_d    = 1'b0;
			ended_d   = 1'b1;
			miss_d    = 2'd0;
			recover_d = 3'd0;
		end else begin
			drive_d = ~drive_q;
			if (drive_d)
				hit = {1'b0, item.sample_value} > up_sum;
			else
				hit = {1'b0, last_q} > down_sum;

			// miss and recovery counters
			if (!hit) begin
				if (miss_q < MISS_MAX)
					miss_d = miss_q + 2'd1;
				hit_run_d = 3'd0;
			end else if (!trip_q) begin
				if (miss_q != 2'd0 && recover_q < COUNT_MAX)
					rc_inc = recover_q + 3'd1;
				recover_d = rc_inc;
				if (rc_inc > RECOVER_LIM) begin
					miss_d    = 2'd0;
					recover_d = 3'd0;
				end
			end

			// run of hits ends a trip
			if (hit && !ended_q) begin
				if (hit_run_q < COUNT_MAX)
					hit_run_d = hit_run_q + 3'd1;
				if (hit_run_d > HIT_RUN_LIM)
					ended_d = 1'b1;
			end

			if (miss_d > MISS_TRIP) begin
				led_d = 1'b1;
				if (!trip_q)
					ended_d = 1'b0;
				trip_d       = 1'b1;
				hold_start_d = item.now_ms;
				miss_d       = 2'd0;
				recover_d    = 3'd0;
			end else if (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_time_ms}) begin
				led_d  = 1'b0;
				trip_d = 1'b0;
			end

			last_d = item.sample_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q      <= 1'b0;
			last_q       <= '0;
			miss_q       <= 2'd0;
			recover_q    <= 3'd0;
			hit_run_q    <= 3'd0;
			trip_q       <= 1'b0;
			ended_q      <= 1'b0;
			led_q        <= 1'b1;
			hold_start_q <= '0;
		end else if (en) begin
			drive_q      <= drive_d;
			last_q       <= last_d;
			miss_q       <= miss_d;
			recover_q    <= recover_d;
			hit_run_q    <= hit_run_d;
			trip_q       <= trip_d;
			ended_q      <= ended_d;
			led_q        <= led_d;
			hold_start_q <= hold_start_d;
		end
	end

	assign res.laser_drive   = drive_d;
	assign res.indicator_led = led_d;
	assign res.tripped       = trip_d;
	assign res.trip_finished = ended_d;

endmodule

`default_nettype wire

// ===== sv/modulated_beam_trip_detector.sv =====
// top level of the modulated beam trip detector: handshakes, registers, result register
// depends on mbtd_pkg and mbtd_core
//
// channel  direction  payload                      handshake
// in       input      in_data (mbtd_pkg::in_t)     in_valid / in_ready
// out      output     out_data (mbtd_pkg::out_t)   out_valid / out_ready
// cfg      input      cfg_index, cfg_data          cfg_valid / cfg_ready
//
// one request per cycle sustained while results are taken; each result passes through
// the input register, then the result register
// the update of each sample is a single pass of compare and counter logic
// reset clears the valid flags and detector state; led comes up set, config registers take their default values
// a held result stalls the input register, and in_ready drops only then
`timescale 1ns / 1ps
`default_nettype none

module modulated_beam_trip_detector (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire mbtd_pkg::in_t                      in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output mbtd_pkg::out_t                          out_data,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [mbtd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mbtd_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import mbtd_pkg::*;

	in_t  item_s1;
	logic valid_s1;
	out_t res_s2;
	logic valid_s2;
	cfg_t cfg_q;
	out_t res;
	logic advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_threshold <= CHANGE_THRESHOLD_RST;
			cfg_q.hold_time_ms     <= HOLD_TIME_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CHANGE_THRESHOLD: cfg_q.change_threshold <= cfg_data[THRESH_W-1:0];
				CFG_HOLD_TIME_MS:     cfg_q.hold_time_ms     <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
		if (advance)
			res_s2 <= res;
	end

	mbtd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

`default_nettype wire

// ===== sv/mbtd_checker.sv =====
// port-level checks for the modulated beam trip detector, bound to the top level
// depends on mbtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mbtd_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire mbtd_pkg::out_t                 out_data
);
	import mbtd_pkg::*;

	// a tripped beam always has its indicator on
	a_trip_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.tripped |-> out_data.indicator_led)
		else $error("tripped without indicator");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output back-pressure");

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a stalled request stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn while stalled");

	// no result right out of reset
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind modulated_beam_trip_detector mbtd_checker u_mbtd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// ===== test/tb_modulated_beam_trip_detector.sv =====
// self-checking testbench for modulated_beam_trip_detector: random valid/ready traffic,
// register writes between phases, and a predictor for the result of each request
// depends on mbtd_pkg and modulated_beam_trip_detector
`timescale 1ns / 1ps

module tb_modulated_beam_trip_detector;
	import mbtd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;
	localparam int IDLE_PCT     = 37;
	localparam int HOLD_OFF_LEN = 400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;

	modulated_beam_trip_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predicted detector state
	logic [THRESH_W-1:0] cfg_thresh  = CHANGE_THRESHOLD_RST;
	logic [HOLD_W-1:0]   cfg_hold    = HOLD_TIME_MS_RST;
	logic                drive_lvl   = 1'b0;
	logic [SAMPLE_W-1:0] prev_read   = '0;
	logic [1:0]          miss_n      = '0;
	logic [2:0]          recover_n   = '0;
	logic [2:0]          hit_run_n   = '0;
	logic                trip_st     = 1'b0;
	logic                ended_st    = 1'b0;
	logic                led_st      = 1'b1;
	logic [TIME_W-1:0]   hold_start  = '0;

	// request generator shadow of drive level and last reading
	logic                gen_drive   = 1'b0;
	logic [SAMPLE_W-1:0] gen_last    = '0;
	logic [TIME_W-1:0]   gen_ms      = '0;

	in_t  sample_req_q[$];
	out_t beam_status_q[$];
	int   mismatches  = 0;
	logic steady_run  = 1'b0;
	logic hold_go     = 1'b0;
	int   hold_left   = 0;

	function automatic out_t beam_next_status(input in_t req);
		int                delta;
		logic              hit;
		logic [TIME_W-1:0] elapsed;
		out_t              res;
		if (req.cmd == CMD_STOP) begin
			drive_lvl = 1'b1;
			led_st    = 1'b0;
			trip_st   = 1'b0;
			ended_st  = 1'b1;
			miss_n    = '0;
			recover_n = '0;
		end else begin
			drive_lvl = ~drive_lvl;
			delta = int'(req.sample_value) - int'(prev_read);
			if (drive_lvl)
				hit = delta > int'(cfg_thresh);
			else
				hit = -delta > int'(cfg_thresh);
			if (!hit) begin
				if (miss_n < MISS_MAX)
					miss_n = miss_n + 2'd1;
				hit_run_n = '0;
			end else if (!trip_st) begin
				if (miss_n != 0 && recover_n < COUNT_MAX)
					recover_n = recover_n + 3'd1;
				if (recover_n > RECOVER_LIM) begin
					miss_n    = '0;
					recover_n = '0;
				end
			end
			if (hit && !ended_st) begin
				if (hit_run_n < COUNT_MAX)
					hit_run_n = hit_run_n + 3'd1;
				if (hit_run_n > HIT_RUN_LIM)
					ended_st = 1'b1;
			end
			elapsed = req.now_ms - hold_start;
			if (miss_n > MISS_TRIP) begin
				led_st = 1'b1;
				if (!trip_st)
					ended_st = 1'b0;
				trip_st    = 1'b1;
				hold_start = req.now_ms;
				miss_n     = '0;
				recover_n  = '0;
			end else if (elapsed >= TIME_W'(cfg_hold)) begin
				led_st  = 1'b0;
				trip_st = 1'b0;
			end
			prev_read = req.sample_value;
		end
		res.laser_drive   = drive_lvl;
		res.indicator_led = led_st;
		res.tripped       = trip_st;
		res.trip_finished = ended_st;
		return res;
	endfunction

	initial forever #1 clk = ~clk;

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				beam_status_q.push_back(beam_next_status(in_data));
			if (!in_valid || in_ready) begin
				if (sample_req_q.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					in_data  <= sample_req_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_go)
			hold_left <= HOLD_OFF_LEN;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_mon
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (beam_status_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: drive %b led %b tripped %b finished %b",
							out_data.laser_drive, out_data.indicator_led,
							out_data.tripped, out_data.trip_finished);
				end else begin
					want = beam_status_q.pop_front();
					if (out_data.laser_drive !== want.laser_drive ||
						out_data.indicator_led !== want.indicator_led ||
						out_data.tripped !== want.tripped ||
						out_data.trip_finished !== want.trip_finished) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected drive %b led %b tripped %b finished %b, got drive %b led %b tripped %b finished %b",
								want.laser_drive, want.indicator_led, want.tripped,
								want.trip_finished, out_data.laser_drive,
								out_data.indicator_led, out_data.tripped,
								out_data.trip_finished);
					end
				end
			end
			out_ready <= (hold_left == 0) && (steady_run || $urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic queue_request(input logic cmd, input logic [SAMPLE_W-1:0] val,
		input logic [TIME_W-1:0] now);
		in_t req;
		req.cmd          = cmd;
		req.sample_value = val;
		req.now_ms       = now;
		sample_req_q.push_back(req);
		if (cmd == CMD_STOP) begin
			gen_drive = 1'b1;
		end else begin
			gen_drive = ~gen_drive;
			gen_last  = val;
		end
	endtask

	// mostly toggling beam patterns, with misses, threshold edges, noise and stops
	task automatic queue_beam_samples(input int n);
		int   mode;
		int   th;
		int   lo;
		int   hi;
		int   last;
		logic up;
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(99);
			th   = int'(cfg_thresh);
			last = int'(gen_last);
			up   = ~gen_drive;
			lo   = 0;
			hi   = 1023;
			case ($urandom_range(99)) inside
				[0:79]:  gen_ms += $urandom_range(50);
				[80:94]: gen_ms += $urandom_range(70000);
				default: gen_ms = $urandom;
			endcase
			if (mode < 3) begin
				queue_request(CMD_STOP, SAMPLE_W'($urandom), $urandom);
			end else begin
				if (mode < 73) begin
					if (up) begin
						lo = last + th + 1;
					end else begin
						hi = last - th - 1;
					end
				end else if (mode < 88) begin
					if (up)
						hi = (last + th > 1023) ? 1023 : last + th;
					else
						lo = (last - th < 0) ? 0 : last - th;
				end else if (mode < 95) begin
					lo = up ? last + th + int'($urandom_range(1)) : last - th - int'($urandom_range(1));
					hi = lo;
				end
				if (lo < 0 || hi > 1023 || lo > hi) begin
					lo = 0;
					hi = 1023;
				end
				queue_request(CMD_SAMPLE, SAMPLE_W'($urandom_range(hi, lo)), gen_ms);
			end
		end
	endtask

	task automatic drain_requests();
		do @(negedge clk);
		while (sample_req_q.size() != 0 || in_valid || beam_status_q.size() != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		steady_run = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_CHANGE_THRESHOLD)
			cfg_thresh = val[THRESH_W-1:0];
		else if (idx == CFG_HOLD_TIME_MS)
			cfg_hold = val[HOLD_W-1:0];
	endtask

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: trip, recovery run, threshold edges, hold expiry, time wrap, stops
		@(negedge clk);
		queue_request(CMD_SAMPLE, 10'd0,    32'd0);
		queue_request(CMD_SAMPLE, 10'd1023, 32'd1);
		queue_request(CMD_SAMPLE, 10'd1023, 32'd2);
		queue_request(CMD_SAMPLE, 10'd0,    32'd3);
		queue_request(CMD_SAMPLE, 10'd1023, 32'd4);
		queue_request(CMD_SAMPLE, 10'd0,    32'd5);
		queue_request(CMD_SAMPLE, 10'd1023, 32'd6);
		queue_request(CMD_SAMPLE, 10'd0,    32'd7);
		queue_request(CMD_SAMPLE, 10'd21,   32'd600);
		queue_request(CMD_SAMPLE, 10'd1,    32'd601);
		queue_request(CMD_SAMPLE, 10'd21,   32'd602);
		queue_request(CMD_STOP,   10'd1023, 32'hFFFF_FFFF);
		queue_request(CMD_SAMPLE, 10'd1023, 32'hFFFF_FFFF);
		queue_request(CMD_SAMPLE, 10'd0,    32'h0000_0100);
		queue_request(CMD_SAMPLE, 10'd1023, 32'h0000_02F3);
		queue_request(CMD_SAMPLE, 10'd0,    32'h0000_02F4);
		queue_request(CMD_STOP,   10'd0,    32'd0);
		queue_request(CMD_STOP,   10'd512,  32'h5555_5555);
		queue_request(CMD_SAMPLE, 10'd1023, 32'h8000_0000);
		queue_request(CMD_SAMPLE, 10'd512,  32'h7FFF_FFFF);
		queue_request(CMD_SAMPLE, 10'd1023, 32'hFFFF_FFFF);
		queue_request(CMD_SAMPLE, 10'd0,    32'd0);
		gen_ms = 32'd0;
		queue_beam_samples(200);
		drain_requests();

		write_reg(CFG_CHANGE_THRESHOLD, 16'hFC00);
		write_reg(CFG_HOLD_TIME_MS, 16'h0000);
		write_reg(CFG_UNUSED_LO, 16'hFFFF);
		write_reg(CFG_UNUSED_HI, 16'hFFFF);
		queue_beam_samples(230);
		drain_requests();

		write_reg(CFG_CHANGE_THRESHOLD, 16'hFFFF);
		write_reg(CFG_HOLD_TIME_MS, 16'hFFFF);
		queue_beam_samples(100);
		drain_requests();

		write_reg(CFG_CHANGE_THRESHOLD, 16'd5);
		write_reg(CFG_HOLD_TIME_MS, 16'd3);
		queue_beam_samples(250);
		drain_requests();

		write_reg(CFG_CHANGE_THRESHOLD, 16'd100);
		write_reg(CFG_HOLD_TIME_MS, 16'd40);
		queue_beam_samples(250);
		drain_requests();

		// no idling on either side
		write_reg(CFG_CHANGE_THRESHOLD, 16'd20);
		write_reg(CFG_HOLD_TIME_MS, 16'd500);
		@(negedge clk);
		steady_run = 1'b1;
		queue_beam_samples(280);
		drain_requests();

		// receiver holds off while requests keep coming
		write_reg(CFG_CHANGE_THRESHOLD, 16'd1);
		write_reg(CFG_HOLD_TIME_MS, 16'd200);
		queue_beam_samples(280);
		hold_go = 1'b1;
		@(negedge clk);
		hold_go = 1'b0;
		drain_requests();

		write_reg(CFG_CHANGE_THRESHOLD, CFG_DAT_W'($urandom_range(200)));
		write_reg(CFG_HOLD_TIME_MS, CFG_DAT_W'($urandom_range(1000)));
		queue_beam_samples(250);
		drain_requests();

		repeat (8) @(posedge clk);
		if (mismatches == 0 && beam_status_q.size() == 0) begin
			$display("status: pass");
		end else begin
			if (beam_status_q.size() != 0)
				$display("%0d expected results never arrived", beam_status_q.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
